### hdl/ncgd_pkg.sv
// Shared types, codes and defaults for the cosine gallery distance block.
package ncgd_pkg;

	localparam int TRACKS_DEF = 16;
	localparam int BUDGET_DEF = 16;
	localparam int DIM_DEF    = 128;

	localparam int QDEPTH = 4;
	localparam int QPW    = 2;

	localparam logic [1:0] MODE_ADD   = 2'd0;
	localparam logic [1:0] MODE_QUERY = 2'd1;
	localparam logic [1:0] MODE_DROP  = 2'd2;
	localparam logic [1:0] MODE_NONE  = 2'd3;

	localparam logic [1:0] CFG_BUDGET = 2'd0;
	localparam logic [1:0] CFG_DIM    = 2'd1;

	localparam logic [4:0] BUDGET_RST = 5'd16;
	localparam logic [7:0] DIM_RST    = 8'd128;

	typedef struct packed {
		logic [1:0]         op;
		logic [3:0]         track;
		logic signed [15:0] value;
		logic               last;
	} item_t;

endpackage

### hdl/ncgd_front.sv
// Front end: accepts input transactions, drops unused codes, queues work items.
module ncgd_front (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [1:0]     mode,
	input  logic [3:0]     track,
	input  logic signed [15:0] value,
	input  logic           last,
	output logic           q_valid,
	output ncgd_pkg::item_t q_item,
	input  logic           q_pop
);
	import ncgd_pkg::*;

	item_t            mem_q [QDEPTH];
	logic [QPW-1:0]   wr_ptr_q;
	logic [QPW-1:0]   rd_ptr_q;
	logic [QPW:0]     count_q;
	logic             push;
	logic             pop;

	assign in_stall = (count_q == (QPW+1)'(QDEPTH));
	assign push     = in_valid && !in_stall && (mode != MODE_NONE);
	assign q_valid  = (count_q != '0);
	assign q_item   = mem_q[rd_ptr_q];
	assign pop      = q_pop && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= '{op: mode, track: track, value: value, last: last};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop) rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

### hdl/ncgd_back.sv
// Back end: gallery memory, track bookkeeping, shared multiply-accumulate and result register.
module ncgd_back #(
	parameter int TRACKS = ncgd_pkg::TRACKS_DEF,
	parameter int BUDGET = ncgd_pkg::BUDGET_DEF,
	parameter int DIM    = ncgd_pkg::DIM_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            q_valid,
	input  ncgd_pkg::item_t q_item,
	output logic            q_pop,
	input  logic [4:0]      budget_cfg,
	input  logic [7:0]      dim_cfg,
	output logic            out_valid,
	input  logic            out_stall,
	output logic [3:0]      result_track,
	output logic [31:0]     distance,
	output logic            no_samples
);
	import ncgd_pkg::*;

	localparam int TW = (TRACKS > 1) ? $clog2(TRACKS) : 1;
	localparam int OW = (BUDGET > 1) ? $clog2(BUDGET) : 1;
	localparam int BW = $clog2(BUDGET + 1);
	localparam int EW = (DIM > 1) ? $clog2(DIM) : 1;
	localparam int DW = $clog2(DIM + 1);
	localparam int DEPTH = TRACKS * BUDGET * DIM;
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MOD  = 3'd1;
	localparam logic [2:0] S_ADD  = 3'd2;
	localparam logic [2:0] S_QRY  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	localparam logic [31:0] DIST_MAX = 32'h8000_0000;

	logic [2:0]         state_q;
	logic [1:0]         op_q;
	logic [TW-1:0]      t_q;
	logic signed [15:0] v_q;
	logic               last_q;
	logic [OW-1:0]      o_q;
	logic [BW-1:0]      c_q;
	logic [BW-1:0]      s_q;
	logic [EW-1:0]      ec_q;
	logic [BW-1:0]      count_q  [TRACKS];
	logic [OW-1:0]      oldest_q [TRACKS];
	logic [39:0]        acc_q    [BUDGET];
	logic [31:0]        best_q;

	logic signed [15:0] gal [DEPTH];
	logic signed [15:0] rdata_s1;
	logic               v_s1;
	logic [OW-1:0]      slot_s1;
	logic signed [31:0] prod_s2;
	logic               v_s2;
	logic [OW-1:0]      slot_s2;

	logic              out_valid_q;
	logic [3:0]        rtrack_q;
	logic [31:0]       dist_q;
	logic              nos_q;

	logic [BW-1:0]     b;
	logic [DW-1:0]     de;
	logic [TW-1:0]     tin;
	logic [BW-1:0]     cin;
	logic              done;
	logic [BW:0]       sum;
	logic [OW-1:0]     slotv;
	logic              wr_en;
	logic              rd_en;
	logic [AW-1:0]     addr;
	logic              clear;
	logic [39:0]       newacc;
	logic signed [40:0] d41;
	logic [31:0]       dsat;
	logic              out_free;
	logic              fire;

	assign b = (budget_cfg == 5'd0) ? BW'(1) :
		((32'(budget_cfg) > BUDGET) ? BW'(BUDGET) : BW'(budget_cfg));
	assign de = (dim_cfg == 8'd0) ? DW'(1) :
		((32'(dim_cfg) > DIM) ? DW'(DIM) : DW'(dim_cfg));
	assign tin = TW'(q_item.track % TRACKS);
	assign cin = (count_q[tin] > b) ? b : count_q[tin];
	assign done = last_q || ((DW+1)'(ec_q) + 1'b1 >= (DW+1)'(de));
	assign sum = (BW+1)'(o_q) + (BW+1)'(c_q);
	assign slotv = (c_q < b) ? ((sum >= (BW+1)'(b)) ? OW'(sum - (BW+1)'(b)) : OW'(sum)) : o_q;
	assign q_pop = (state_q == S_IDLE) && q_valid;
	assign wr_en = (state_q == S_ADD);
	assign rd_en = (state_q == S_QRY) && (s_q < c_q);
	assign addr = AW'((32'(t_q) * BUDGET + 32'(wr_en ? slotv : OW'(s_q))) * DIM + 32'(ec_q));
	assign clear = (state_q == S_MOD) && !(32'(o_q) >= 32'(b)) && (op_q == MODE_QUERY)
		&& (ec_q == '0);
	assign newacc = acc_q[slot_s2] + {{8{prod_s2[31]}}, prod_s2};
	assign d41 = 41'sh0_4000_0000 - $signed({newacc[39], newacc});
	assign dsat = d41[40] ? 32'd0 : ((d41 > 41'sh0_8000_0000) ? DIST_MAX : d41[31:0]);
	assign out_free = !out_valid_q || !out_stall;
	assign fire = (state_q == S_FIN) && done && out_free;

	assign out_valid    = out_valid_q;
	assign result_track = rtrack_q;
	assign distance     = dist_q;
	assign no_samples   = nos_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			gal[addr] <= v_q;
		end else if (rd_en) begin
			rdata_s1 <= gal[addr];
		end
	end

	always_ff @(posedge clk) begin
		slot_s1 <= OW'(s_q);
		prod_s2 <= v_q * rdata_s1;
		slot_s2 <= slot_s1;
		op_q    <= q_pop ? q_item.op : op_q;
		v_q     <= q_pop ? q_item.value : v_q;
		last_q  <= q_pop ? q_item.last : last_q;
		t_q     <= q_pop ? tin : t_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < BUDGET; i++) acc_q[i] <= '0;
		end else if (clear) begin
			for (int i = 0; i < BUDGET; i++) acc_q[i] <= '0;
		end else if (v_s2) begin
			acc_q[slot_s2] <= newacc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			o_q         <= '0;
			c_q         <= '0;
			s_q         <= '0;
			ec_q        <= '0;
			best_q      <= DIST_MAX;
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			out_valid_q <= 1'b0;
			rtrack_q    <= '0;
			dist_q      <= '0;
			nos_q       <= 1'b0;
			for (int i = 0; i < TRACKS; i++) begin
				count_q[i]  <= '0;
				oldest_q[i] <= '0;
			end
		end else begin
			v_s1 <= rd_en;
			v_s2 <= v_s1;
			if (v_s2 && (dsat < best_q)) best_q <= dsat;
			if (fire) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						if (q_item.op == MODE_DROP) begin
							count_q[tin]  <= '0;
							oldest_q[tin] <= '0;
							ec_q          <= '0;
						end else begin
							o_q     <= oldest_q[tin];
							c_q     <= cin;
							state_q <= S_MOD;
						end
					end
				end
				S_MOD: begin
					if (32'(o_q) >= 32'(b)) begin
						o_q <= o_q - OW'(b);
					end else if (op_q == MODE_ADD) begin
						state_q <= S_ADD;
					end else begin
						s_q     <= '0;
						best_q  <= DIST_MAX;
						state_q <= S_QRY;
					end
				end
				S_ADD: begin
					if (done) begin
						if (c_q < b) begin
							count_q[t_q]  <= c_q + 1'b1;
							oldest_q[t_q] <= o_q;
						end else begin
							count_q[t_q]  <= b;
							oldest_q[t_q] <= ((BW+1)'(o_q) + 1'b1 == (BW+1)'(b)) ? '0
								: o_q + 1'b1;
						end
						ec_q <= '0;
					end else begin
						ec_q <= ec_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_QRY: begin
					if (rd_en) begin
						s_q <= s_q + 1'b1;
					end else if (!v_s1 && !v_s2) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (!done) begin
						ec_q    <= ec_q + 1'b1;
						state_q <= S_IDLE;
					end else if (out_free) begin
						rtrack_q    <= 4'(t_q);
						dist_q      <= (c_q == '0) ? DIST_MAX : best_q;
						nos_q       <= (c_q == '0);
						ec_q        <= '0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

### hdl/nn_cosine_gallery_distance.sv
// Top level of the per-track cosine gallery distance block.
// Each track keeps a first-in first-out gallery of up to budget_in_use feature samples of
// dim_in_use Q1.15 elements, in one memory of TRACKS*BUDGET*DIM words. Input transactions are
// queued in a four-entry buffer ahead of the execution side. A drop empties the track; an add
// element writes one word; a query element reads each sample held by the track, one at a
// time, as one memory read port and one multiply-accumulate serve the samples in turn, and
// the two-stage pipeline drains before the element ends. An add or query element first
// subtracts whole budgets from the stored oldest slot until it is below the budget (normally
// none). A query's final element puts minimum(1 - dot) in Q2.30 into an output register
// and waits while that register holds a stalled result.
// No clearing pass follows reset.
module nn_cosine_gallery_distance #(
	parameter int TRACKS = ncgd_pkg::TRACKS_DEF,
	parameter int BUDGET = ncgd_pkg::BUDGET_DEF,
	parameter int DIM    = ncgd_pkg::DIM_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [1:0]         mode,
	input  logic [3:0]         track,
	input  logic signed [15:0] value,
	input  logic               last,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [3:0]         result_track,
	output logic [31:0]        distance,
	output logic               no_samples,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [7:0]         cfg_data
);
	import ncgd_pkg::*;

	logic       q_valid;
	item_t      q_item;
	logic       q_pop;
	logic [4:0] budget_q;
	logic [7:0] dim_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			budget_q <= BUDGET_RST;
			dim_q    <= DIM_RST;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == CFG_BUDGET) budget_q <= cfg_data[4:0];
			else if (cfg_index == CFG_DIM) dim_q <= cfg_data;
		end
	end

	ncgd_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.track    (track),
		.value    (value),
		.last     (last),
		.q_valid  (q_valid),
		.q_item   (q_item),
		.q_pop    (q_pop)
	);

	ncgd_back #(
		.TRACKS (TRACKS),
		.BUDGET (BUDGET),
		.DIM    (DIM)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_item       (q_item),
		.q_pop        (q_pop),
		.budget_cfg   (budget_q),
		.dim_cfg      (dim_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.result_track (result_track),
		.distance     (distance),
		.no_samples   (no_samples)
	);

endmodule
